// ----- hw/rtl/tac_pkg.sv -----
// Shared types, widths and result codes for the triangle angle classifier.
// No dependencies; every other file in this block refers to it by scoped names.
`default_nettype none

package tac_pkg;

    localparam int COORD_BITS = 16;
    localparam int SQ_W       = 2 * COORD_BITS;     // one squared delta
    localparam int DIST_W     = SQ_W + 1;           // squared side length
    localparam int MAG_W      = DIST_W + 1;         // |A + B - C|
    localparam int MAGSQ_W    = 2 * MAG_W;          // d squared
    localparam int PROD_W     = 2 * DIST_W;         // A * B
    localparam int HALF_W     = PROD_W / 2;         // split of A * B for the tolerance multiply
    localparam int TOL_W      = 21;
    localparam int TOL_FRAC   = 20;
    localparam int PP_W       = HALF_W + TOL_W;     // one partial product
    localparam int PT_W       = PROD_W + TOL_W;     // A * B * tol
    localparam int CMP_W      = MAGSQ_W + TOL_FRAC; // width of both sides of the compare

    localparam logic [TOL_W-1:0] TOL_ONE   = TOL_W'(1048576);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7965);

    localparam logic [1:0] CLASS_FAIL   = 2'd0;
    localparam logic [1:0] CLASS_RIGHT  = 2'd1;
    localparam logic [1:0] CLASS_ACUTE  = 2'd2;
    localparam logic [1:0] CLASS_OBTUSE = 2'd3;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [DIST_W-1:0]     dist_t;
    typedef logic [MAG_W-1:0]      mag_t;
    typedef logic [TOL_W-1:0]      tol_t;

    // Sorted sides with the sign and size of d.
    typedef struct packed {
        dist_t a;
        dist_t b;
        mag_t  mag;
        logic  neg;
        logic  zero;
    } side_t;

    // Both sides of the final compare, before the last add.
    typedef struct packed {
        logic [MAGSQ_W-1:0] mag_sq;
        logic [PP_W-1:0]    pp_hi;
        logic [PP_W-1:0]    pp_lo;
        logic               neg;
        logic               zero;
    } prod_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tac_dist.sv -----
// Three pipeline stages: coordinate deltas, squares, squared side lengths.
// Depends on tac_pkg.
`default_nettype none

module tac_dist (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire tac_pkg::coord_t x1,
    input  wire tac_pkg::coord_t y1,
    input  wire tac_pkg::coord_t x2,
    input  wire tac_pkg::coord_t y2,
    input  wire tac_pkg::coord_t x3,
    input  wire tac_pkg::coord_t y3,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output tac_pkg::dist_t       e1,
    output tac_pkg::dist_t       e2,
    output tac_pkg::dist_t       e3
);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    tac_pkg::coord_t d_reg [6];
    tac_pkg::coord_t d_next [6];
    logic [tac_pkg::SQ_W-1:0] sq_reg [6];
    tac_pkg::dist_t e_reg [3];

    function automatic tac_pkg::coord_t abs_diff(tac_pkg::coord_t p, tac_pkg::coord_t q);
        abs_diff = (p >= q) ? p - q : q - p;
    endfunction

    // A stage takes new data when it is empty or its contents move on.
    assign rdy3     = !v3_reg || !out_stall;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_comb
    begin
        d_next[0] = abs_diff(x1, x2);
        d_next[1] = abs_diff(y1, y2);
        d_next[2] = abs_diff(x1, x3);
        d_next[3] = abs_diff(y1, y3);
        d_next[4] = abs_diff(x3, x2);
        d_next[5] = abs_diff(y3, y2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            for (int i = 0; i < 6; i++)
            begin
                d_reg[i] <= d_next[i];
            end
        end
        if (rdy2)
        begin
            for (int i = 0; i < 6; i++)
            begin
                sq_reg[i] <= tac_pkg::SQ_W'(d_reg[i]) * tac_pkg::SQ_W'(d_reg[i]);
            end
        end
        if (rdy3)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e_reg[i] <= tac_pkg::DIST_W'(sq_reg[2*i]) + tac_pkg::DIST_W'(sq_reg[2*i+1]);
            end
        end
    end

    assign out_valid = v3_reg;
    assign e1        = e_reg[0];
    assign e2        = e_reg[1];
    assign e3        = e_reg[2];

endmodule

`default_nettype wire

// ----- hw/rtl/tac_sort.sv -----
// Two pipeline stages: sort the squared sides, then form d = A + B - C.
// Depends on tac_pkg.
`default_nettype none

module tac_sort (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire tac_pkg::dist_t e1,
    input  wire tac_pkg::dist_t e2,
    input  wire tac_pkg::dist_t e3,
    output logic                out_valid,
    input  wire logic           out_stall,
    output tac_pkg::side_t      side
);

    logic v4_reg, v5_reg;
    logic rdy4, rdy5;

    tac_pkg::dist_t a_reg, b_reg, c_reg;
    tac_pkg::dist_t a_next, b_next, c_next, hi12;
    logic           zero_reg;
    tac_pkg::side_t side_reg;
    tac_pkg::side_t side_next;
    tac_pkg::mag_t  sum;
    tac_pkg::mag_t  c_ext;

    assign rdy5     = !v5_reg || !out_stall;
    assign rdy4     = !v4_reg || rdy5;
    assign in_stall = !rdy4;

    always_comb
    begin
        if (e1 >= e2)
        begin
            hi12   = e1;
            a_next = e2;
        end
        else
        begin
            hi12   = e2;
            a_next = e1;
        end
        if (hi12 >= e3)
        begin
            b_next = e3;
            c_next = hi12;
        end
        else
        begin
            b_next = hi12;
            c_next = e3;
        end
    end

    always_comb
    begin
        sum   = tac_pkg::MAG_W'(a_reg) + tac_pkg::MAG_W'(b_reg);
        c_ext = tac_pkg::MAG_W'(c_reg);
        side_next.a    = a_reg;
        side_next.b    = b_reg;
        side_next.zero = zero_reg;
        side_next.neg  = (sum < c_ext);
        side_next.mag  = (sum < c_ext) ? c_ext - sum : sum - c_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
            begin
                v4_reg <= in_valid;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            // The shortest side is zero exactly when any side is zero.
            zero_reg <= (e1 == '0) || (e2 == '0) || (e3 == '0);
        end
        if (rdy5)
        begin
            side_reg <= side_next;
        end
    end

    assign out_valid = v5_reg;
    assign side      = side_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tac_mult.sv -----
// Two pipeline stages: d squared and A * B, then A * B times the tolerance
// as two partial products. Depends on tac_pkg.
`default_nettype none

module tac_mult (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire tac_pkg::side_t side,
    input  wire tac_pkg::tol_t  tol,
    output logic                out_valid,
    input  wire logic           out_stall,
    output tac_pkg::prod_t      prod
);

    logic v6_reg, v7_reg;
    logic rdy6, rdy7;

    logic [tac_pkg::MAGSQ_W-1:0] mag_sq_reg;
    logic [tac_pkg::PROD_W-1:0]  ab_reg;
    logic                        neg_reg;
    logic                        zero_reg;
    tac_pkg::prod_t              prod_reg;

    assign rdy7     = !v7_reg || !out_stall;
    assign rdy6     = !v6_reg || rdy7;
    assign in_stall = !rdy6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (rdy6)
            begin
                v6_reg <= in_valid;
            end
            if (rdy7)
            begin
                v7_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            mag_sq_reg <= tac_pkg::MAGSQ_W'(side.mag) * tac_pkg::MAGSQ_W'(side.mag);
            ab_reg     <= tac_pkg::PROD_W'(side.a) * tac_pkg::PROD_W'(side.b);
            neg_reg    <= side.neg;
            zero_reg   <= side.zero;
        end
        if (rdy7)
        begin
            prod_reg.mag_sq <= mag_sq_reg;
            prod_reg.pp_lo  <= tac_pkg::PP_W'(ab_reg[tac_pkg::HALF_W-1:0])
                               * tac_pkg::PP_W'(tol);
            prod_reg.pp_hi  <= tac_pkg::PP_W'(ab_reg[tac_pkg::PROD_W-1:tac_pkg::HALF_W])
                               * tac_pkg::PP_W'(tol);
            prod_reg.neg    <= neg_reg;
            prod_reg.zero   <= zero_reg;
        end
    end

    assign out_valid = v7_reg;
    assign prod      = prod_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/triangle_angle_classifier.sv -----
// Triangle classifier by the angle opposite the longest side.
// Pipeline: eight register stages from the input to out_valid.
// Throughput: one item per cycle while out_stall is low, set by eight register
// stages that each advance whenever the stage after them is empty or moving.
// Reset empties the pipeline and sets the tolerance to five degrees.
`default_nettype none

module triangle_angle_classifier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] ax,
    input  wire logic [15:0] ay,
    input  wire logic [15:0] bx,
    input  wire logic [15:0] by_coord,
    input  wire logic [15:0] cx,
    input  wire logic [15:0] cy,
    input  wire logic        right_tolerance_sq_we,
    input  wire logic [20:0] right_tolerance_sq,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       shape_class
);

    tac_pkg::tol_t  tol_reg;
    logic           dist_valid, dist_stall;
    tac_pkg::dist_t e1, e2, e3;
    logic           sort_valid, sort_stall;
    tac_pkg::side_t side;
    logic           mult_valid, mult_stall;
    tac_pkg::prod_t prod;

    logic             out_valid_reg;
    logic [1:0]       shape_class_reg;
    logic [1:0]       shape_class_next;
    logic             rdy8;
    logic [tac_pkg::PT_W-1:0]  ab_tol;
    logic [tac_pkg::CMP_W-1:0] lhs, rhs;

    // Values above one are held at one when written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= tac_pkg::TOL_RESET;
        end
        else if (right_tolerance_sq_we)
        begin
            tol_reg <= (right_tolerance_sq > tac_pkg::TOL_ONE) ? tac_pkg::TOL_ONE
                                                               : right_tolerance_sq;
        end
    end

    tac_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x1        (ax[tac_pkg::COORD_BITS-1:0]),
        .y1        (ay[tac_pkg::COORD_BITS-1:0]),
        .x2        (bx[tac_pkg::COORD_BITS-1:0]),
        .y2        (by_coord[tac_pkg::COORD_BITS-1:0]),
        .x3        (cx[tac_pkg::COORD_BITS-1:0]),
        .y3        (cy[tac_pkg::COORD_BITS-1:0]),
        .out_valid (dist_valid),
        .out_stall (dist_stall),
        .e1        (e1),
        .e2        (e2),
        .e3        (e3)
    );

    tac_sort u_sort (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dist_valid),
        .in_stall  (dist_stall),
        .e1        (e1),
        .e2        (e2),
        .e3        (e3),
        .out_valid (sort_valid),
        .out_stall (sort_stall),
        .side      (side)
    );

    tac_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sort_valid),
        .in_stall  (sort_stall),
        .side      (side),
        .tol       (tol_reg),
        .out_valid (mult_valid),
        .out_stall (mult_stall),
        .prod      (prod)
    );

    assign rdy8       = !out_valid_reg || !out_stall;
    assign mult_stall = !rdy8;

    // Right when d^2 * 2^20 < 4 * A * B * tol; exactly on the boundary is a failure.
    always_comb
    begin
        ab_tol = (tac_pkg::PT_W'(prod.pp_hi) << tac_pkg::HALF_W) + tac_pkg::PT_W'(prod.pp_lo);
        rhs    = {ab_tol[tac_pkg::CMP_W-3:0], 2'b00};
        lhs    = {prod.mag_sq, {tac_pkg::TOL_FRAC{1'b0}}};
        if (prod.zero)
        begin
            shape_class_next = tac_pkg::CLASS_FAIL;
        end
        else if (lhs < rhs)
        begin
            shape_class_next = tac_pkg::CLASS_RIGHT;
        end
        else if (lhs == rhs)
        begin
            shape_class_next = tac_pkg::CLASS_FAIL;
        end
        else if (prod.neg)
        begin
            shape_class_next = tac_pkg::CLASS_OBTUSE;
        end
        else
        begin
            shape_class_next = tac_pkg::CLASS_ACUTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rdy8)
        begin
            out_valid_reg <= mult_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy8)
        begin
            shape_class_reg <= shape_class_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign shape_class = shape_class_reg;

`ifndef SYNTHESIS
    a_tol_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        right_tolerance_sq_we |=> tol_reg <= tac_pkg::TOL_ONE)
        else $error("tolerance register above one");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && mult_valid))
        else $error("input stalled while the pipeline has room");

    a_zero_side_fails: assert property (@(posedge clk) disable iff (!rst_n)
        (mult_valid && rdy8 && prod.zero) |=> shape_class == tac_pkg::CLASS_FAIL)
        else $error("zero-length side not reported as failure");
`endif

endmodule

`default_nettype wire
